FILE: hdl/apf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apf_pkg: shared types and constants of the dual-channel audio packet FIFO
// Ring geometry, item formats, command and result codes, statistic indexes.
// ----------------------------------------------------------------------------
package apf_pkg;

  localparam int RING_DEPTH        = 4096;
  localparam int BYTES_PER_CHANNEL = 16;

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int REM_W  = $clog2(2 * BYTES_PER_CHANNEL + 1);

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_DRAIN = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_BYTE      = 3'd1,
    KIND_SHORT     = 3'd2,
    KIND_STAT      = 3'd3,
    KIND_BAD_INDEX = 3'd4
  } kind_t;

  localparam logic [0:0] REG_STEREO_MODE    = 1'b0;
  localparam logic [0:0] REG_ENCODER_ENABLE = 1'b1;

  localparam logic [3:0] STAT_IN_L   = 4'd0;
  localparam logic [3:0] STAT_IN_R   = 4'd1;
  localparam logic [3:0] STAT_OUT_L  = 4'd2;
  localparam logic [3:0] STAT_OUT_R  = 4'd3;
  localparam logic [3:0] STAT_FILL_L = 4'd4;
  localparam logic [3:0] STAT_FILL_R = 4'd5;
  localparam logic [3:0] STAT_MAX_L  = 4'd6;
  localparam logic [3:0] STAT_MAX_R  = 4'd7;
  localparam logic [3:0] STAT_MIN_L  = 4'd8;
  localparam logic [3:0] STAT_MIN_R  = 4'd9;

  typedef struct packed {
    cmd_t       command;
    logic       channel;
    logic [7:0] data_byte;
    logic [3:0] stat_index;
  } in_item_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [31:0] result_value;
    logic        last_of_run;
  } out_item_t;

  typedef logic [1:0][FILL_W-1:0] fill_pair_t;

  // One fill change of one ring, or a statistics reset.
  typedef struct packed {
    logic              upd;
    logic              clr;
    logic              ch;
    logic              drained;
    logic [FILL_W-1:0] fill;
  } stat_evt_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [PTR_W-1:0] addr;
    logic [7:0]       wdata;
  } ram_ctl_t;

endpackage

FILE: hdl/apf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module apf_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/apf_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apf_stats: per-channel traffic counters and fill watermarks
// Counts bytes in and out, tracks minimum and maximum fill, and serves reads.
// ----------------------------------------------------------------------------
module apf_stats (
  input  logic                clk,
  input  logic                rst,
  input  apf_pkg::stat_evt_t  evt,
  input  apf_pkg::fill_pair_t fill,
  input  logic [3:0]          sel,
  output logic [31:0]         value,
  output logic                bad
);
  import apf_pkg::*;

  logic [3:0][31:0]       count;
  logic [1:0][FILL_W-1:0] max_fill;
  logic [1:0][FILL_W-1:0] min_fill;
  logic [1:0]             cidx;
  logic [31:0]            count_inc;

  // A single incrementer serves all four counters; bit 1 selects bytes out.
  assign cidx      = {evt.drained, evt.ch};
  assign count_inc = count[cidx] + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      max_fill <= '0;
      min_fill <= '0;
    end else if (evt.clr) begin
      count    <= '0;
      max_fill <= fill;
      min_fill <= fill;
    end else if (evt.upd) begin
      count[cidx] <= count_inc;
      if (evt.fill > max_fill[evt.ch]) begin
        max_fill[evt.ch] <= evt.fill;
      end
      if (evt.fill < min_fill[evt.ch]) begin
        min_fill[evt.ch] <= evt.fill;
      end
    end
  end

  always_comb begin
    value = '0;
    bad   = 1'b0;
    unique case (sel)
      STAT_IN_L:   value = count[0];
      STAT_IN_R:   value = count[1];
      STAT_OUT_L:  value = count[2];
      STAT_OUT_R:  value = count[3];
      STAT_FILL_L: value = 32'(fill[0]);
      STAT_FILL_R: value = 32'(fill[1]);
      STAT_MAX_L:  value = 32'(max_fill[0]);
      STAT_MAX_R:  value = 32'(max_fill[1]);
      STAT_MIN_L:  value = 32'(min_fill[0]);
      STAT_MIN_R:  value = 32'(min_fill[1]);
      default:     bad   = 1'b1;
    endcase
  end

endmodule

FILE: hdl/apf_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apf_seq: command sequencer of the audio packet FIFO
// Holds ring pointers and fill levels, steps them through one shared pointer
// and fill unit, and drives the result register.
// ----------------------------------------------------------------------------
module apf_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  apf_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output apf_pkg::out_item_t  out_data,
  input  logic                stereo_mode,
  input  logic                encoder_enable,
  output apf_pkg::ram_ctl_t   ram_l,
  output apf_pkg::ram_ctl_t   ram_r,
  input  logic [7:0]          rdata_l,
  input  logic [7:0]          rdata_r,
  output apf_pkg::stat_evt_t  evt,
  output apf_pkg::fill_pair_t fill,
  output logic [3:0]          stat_sel,
  input  logic [31:0]         stat_value,
  input  logic                stat_bad
);
  import apf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_DRAIN,
    S_RADDR,
    S_RDATA,
    S_STAT,
    S_CLEAR
  } state_t;

  state_t                state;
  in_item_t              item;
  logic [1:0][PTR_W-1:0] wp;
  logic [1:0][PTR_W-1:0] rp;
  logic                  sel;
  logic [REM_W-1:0]      remaining;

  logic              push_op;
  logic              wch;
  logic [PTR_W-1:0]  ptr_cur;
  logic [PTR_W-1:0]  ptr_inc;
  logic [FILL_W-1:0] fill_cur;
  logic [FILL_W-1:0] fill_new;
  logic              full;
  logic              drain_ok;
  logic              slot_free;
  logic [7:0]        rd_byte;

  // Shared step unit: one pointer incrementer and one fill adder. A push and
  // a drained byte both go through it; on a full ring the read pointer equals
  // the write pointer, so both take the same incremented value.
  always_comb begin
    push_op  = (state == S_PUSH);
    wch      = push_op ? item.channel : sel;
    ptr_cur  = push_op ? wp[wch] : rp[wch];
    ptr_inc  = (ptr_cur == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_cur + 1'b1;
    fill_cur = fill[wch];
    full     = (fill_cur == FILL_W'(RING_DEPTH));
    if (push_op) begin
      fill_new = full ? fill_cur : fill_cur + 1'b1;
    end else begin
      fill_new = fill_cur - 1'b1;
    end
  end

  always_comb begin
    if (stereo_mode) begin
      drain_ok = (fill[0] >= FILL_W'(BYTES_PER_CHANNEL)) &&
                 (fill[1] >= FILL_W'(BYTES_PER_CHANNEL));
    end else begin
      drain_ok = (fill[1] >= FILL_W'(2 * BYTES_PER_CHANNEL));
    end
  end

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign rd_byte   = sel ? rdata_r : rdata_l;
  assign stat_sel  = item.stat_index;

  always_comb begin
    ram_l.we    = push_op && !item.channel;
    ram_l.re    = (state == S_RADDR) && !sel;
    ram_l.addr  = ptr_cur;
    ram_l.wdata = item.data_byte;
    ram_r.we    = push_op && item.channel;
    ram_r.re    = (state == S_RADDR) && sel;
    ram_r.addr  = ptr_cur;
    ram_r.wdata = item.data_byte;
  end

  always_comb begin
    evt.upd     = push_op || (state == S_RADDR);
    evt.clr     = (state == S_CLEAR);
    evt.ch      = wch;
    evt.drained = (state == S_RADDR);
    evt.fill    = fill_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      wp        <= '0;
      rp        <= '0;
      fill      <= '0;
    end else begin
      // The result register loads in exactly the states that emit a result.
      if (slot_free) begin
        out_valid <= (state == S_DRAIN) || (state == S_RDATA) || (state == S_STAT);
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            unique case (in_data.command)
              CMD_PUSH:  state <= S_PUSH;
              CMD_DRAIN: state <= S_DRAIN;
              CMD_CLEAR: state <= S_CLEAR;
              CMD_READ:  state <= S_STAT;
            endcase
          end
        end
        S_PUSH: begin
          wp[wch]   <= ptr_inc;
          fill[wch] <= fill_new;
          if (full) begin
            rp[wch] <= ptr_inc;
          end
          state <= S_IDLE;
        end
        S_DRAIN: begin
          if (slot_free) begin
            if (!drain_ok) begin
              out_data <= '{result_kind: KIND_SHORT, result_value: '0, last_of_run: 1'b1};
              state    <= S_IDLE;
            end else begin
              out_data <= '{result_kind: KIND_HEADER,
                            result_value: 32'({encoder_enable, stereo_mode}),
                            last_of_run: 1'b0};
              sel       <= !stereo_mode;
              remaining <= stereo_mode ? REM_W'(BYTES_PER_CHANNEL)
                                       : REM_W'(2 * BYTES_PER_CHANNEL);
              state     <= S_RADDR;
            end
          end
        end
        S_RADDR: begin
          // The RAM read is issued at the old pointer in this cycle.
          rp[wch]   <= ptr_inc;
          fill[wch] <= fill_new;
          state     <= S_RDATA;
        end
        S_RDATA: begin
          if (slot_free) begin
            out_data  <= '{result_kind: KIND_BYTE,
                           result_value: 32'(rd_byte),
                           last_of_run: sel && (remaining == REM_W'(1))};
            if (remaining == REM_W'(1)) begin
              if (!sel) begin
                sel       <= 1'b1;
                remaining <= REM_W'(BYTES_PER_CHANNEL);
                state     <= S_RADDR;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              remaining <= remaining - 1'b1;
              state     <= S_RADDR;
            end
          end
        end
        S_STAT: begin
          if (slot_free) begin
            out_data  <= '{result_kind: stat_bad ? KIND_BAD_INDEX : KIND_STAT,
                           result_value: stat_value,
                           last_of_run: 1'b1};
            state     <= S_IDLE;
          end
        end
        S_CLEAR: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/dual_channel_audio_packet_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_channel_audio_packet_fifo: two overwriting byte rings with packet drain
// Left and right byte rings, a packet drain with header, and statistics.
// ----------------------------------------------------------------------------
// A push, a statistics reset, a statistics read and a refused drain each pass
// through the transfer in S_IDLE and one working state. A full drain emits a
// header and then 2 * BYTES_PER_CHANNEL packet bytes; each packet byte is read
// from the ring RAM in S_RADDR through its single read port, whose data is
// registered, and loaded into the result register in S_RDATA. The input is
// stalled while an item is at work; an output stall holds the drain and
// statistics read states until the result slot is free. A finished last result
// may sit in the result register while the next input transfer is taken. There
// is no clearing pass after reset; ring entries are only read inside the filled
// region.
module dual_channel_audio_packet_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  apf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output apf_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [0:0]         cfg_data
);
  import apf_pkg::*;

  logic       stereo_mode;
  logic       encoder_enable;
  ram_ctl_t   ram_l;
  ram_ctl_t   ram_r;
  logic [7:0] rdata_l;
  logic [7:0] rdata_r;
  stat_evt_t  evt;
  fill_pair_t fill;
  logic [3:0] stat_sel;
  logic [31:0] stat_value;
  logic       stat_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_mode    <= 1'b0;
      encoder_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEREO_MODE:    stereo_mode    <= cfg_data[0];
        REG_ENCODER_ENABLE: encoder_enable <= cfg_data[0];
      endcase
    end
  end

  apf_ram #(.DEPTH(RING_DEPTH), .WIDTH(8)) u_ram_l (
    .clk   (clk),
    .we    (ram_l.we),
    .waddr (ram_l.addr),
    .wdata (ram_l.wdata),
    .re    (ram_l.re),
    .raddr (ram_l.addr),
    .rdata (rdata_l)
  );

  apf_ram #(.DEPTH(RING_DEPTH), .WIDTH(8)) u_ram_r (
    .clk   (clk),
    .we    (ram_r.we),
    .waddr (ram_r.addr),
    .wdata (ram_r.wdata),
    .re    (ram_r.re),
    .raddr (ram_r.addr),
    .rdata (rdata_r)
  );

  apf_stats u_stats (
    .clk   (clk),
    .rst   (rst),
    .evt   (evt),
    .fill  (fill),
    .sel   (stat_sel),
    .value (stat_value),
    .bad   (stat_bad)
  );

  apf_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .stereo_mode    (stereo_mode),
    .encoder_enable (encoder_enable),
    .ram_l          (ram_l),
    .ram_r          (ram_r),
    .rdata_l        (rdata_l),
    .rdata_r        (rdata_r),
    .evt            (evt),
    .fill           (fill),
    .stat_sel       (stat_sel),
    .stat_value     (stat_value),
    .stat_bad       (stat_bad)
  );

  // A ring never holds more bytes than it has entries.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill[0] <= FILL_W'(RING_DEPTH) && fill[1] <= FILL_W'(RING_DEPTH))
    else $error("ring fill level above ring depth");

  // The fill seen by the statistics is the fill the ring takes next.
  a_fill_left: assert property (@(posedge clk) disable iff (rst)
    evt.upd && !evt.ch |=> fill[0] == $past(evt.fill))
    else $error("left fill does not match statistics update");

  a_fill_right: assert property (@(posedge clk) disable iff (rst)
    evt.upd && evt.ch |=> fill[1] == $past(evt.fill))
    else $error("right fill does not match statistics update");

  // Ring writes and ring reads belong to different commands.
  a_ram_excl: assert property (@(posedge clk) disable iff (rst)
    !((ram_l.we || ram_r.we) && (ram_l.re || ram_r.re)))
    else $error("ring write and ring read in the same cycle");

endmodule
